FILE: design/retransmit_backoff_timer_macros.svh
// Assertion macros for the retransmit back-off timer checker
`ifndef RETRANSMIT_BACKOFF_TIMER_MACROS_SVH
`define RETRANSMIT_BACKOFF_TIMER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define RBT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define RBT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/rbt_pkg.sv
// Package: types, codes, reset values and jitter arithmetic for the back-off timer
`timescale 1ns / 1ps

package rbt_pkg;

  localparam int TimeW  = 32;
  localparam int CountW = 16;
  localparam int JitW   = 13;
  localparam int WideW  = 36;
  localparam int ProdW  = JitW + TimeW + 1;
  localparam int AddrW  = 4;

  localparam logic [TimeW-1:0]  TIME_MAX  = '1;
  localparam logic [CountW-1:0] COUNT_MAX = '1;

  // register map, word index taken from paddr[3:2]
  localparam logic [1:0] REG_INITIAL_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_MAX_TIMEOUT     = 2'd1;
  localparam logic [1:0] REG_MAX_COUNT       = 2'd2;
  localparam logic [1:0] REG_MAX_DURATION    = 2'd3;

  localparam logic [TimeW-1:0]  RST_INITIAL_TIMEOUT = 32'd1;
  localparam logic [TimeW-1:0]  RST_MAX_TIMEOUT     = 32'd30;
  localparam logic [CountW-1:0] RST_MAX_COUNT       = 16'd10;
  localparam logic [TimeW-1:0]  RST_MAX_DURATION    = 32'd0;

  localparam logic REQ_FIRST = 1'b0;
  localparam logic REQ_RETRY = 1'b1;

  localparam logic [1:0] CAUSE_NONE     = 2'd0;
  localparam logic [1:0] CAUSE_COUNT    = 2'd1;
  localparam logic [1:0] CAUSE_DURATION = 2'd2;

  typedef struct packed {
    logic [TimeW-1:0]  initial_timeout;
    logic [TimeW-1:0]  max_timeout;
    logic [CountW-1:0] max_count;
    logic [TimeW-1:0]  max_duration;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0]  cur_timeout;
    logic [TimeW-1:0]  total_elapsed;
    logic [CountW-1:0] send_count;
  } state_t;

  typedef struct packed {
    logic       scheduled;
    logic [1:0] give_up_cause;
    state_t     state;
  } result_t;

  // (j * base) / 2^15, rounded toward zero
  function automatic logic signed [WideW-1:0] jitter_term(
      input logic signed [JitW-1:0] j, input logic [TimeW-1:0] base);
    logic signed [ProdW-1:0] prod;
    logic signed [ProdW-1:0] adj;
    prod = $signed({1'b0, base}) * j;
    adj  = prod[ProdW-1] ? prod + ProdW'(32767) : prod;
    return {{(WideW - (ProdW - 15)){adj[ProdW-1]}}, adj[ProdW-1:15]};
  endfunction

endpackage

FILE: design/rbt_cfg.sv
// APB-style configuration register file for the back-off timer
`timescale 1ns / 1ps

module rbt_cfg
  import rbt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_timeout <= RST_INITIAL_TIMEOUT;
      cfg.max_timeout     <= RST_MAX_TIMEOUT;
      cfg.max_count       <= RST_MAX_COUNT;
      cfg.max_duration    <= RST_MAX_DURATION;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_INITIAL_TIMEOUT: cfg.initial_timeout <= pwdata;
        REG_MAX_TIMEOUT:     cfg.max_timeout     <= pwdata;
        REG_MAX_COUNT:       cfg.max_count       <= pwdata[CountW-1:0];
        REG_MAX_DURATION:    cfg.max_duration    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_INITIAL_TIMEOUT: prdata = cfg.initial_timeout;
      REG_MAX_TIMEOUT:     prdata = cfg.max_timeout;
      REG_MAX_COUNT:       prdata = {{(32 - CountW){1'b0}}, cfg.max_count};
      REG_MAX_DURATION:    prdata = cfg.max_duration;
      default:             prdata = '0;
    endcase
  end

endmodule

FILE: design/rbt_calc.sv
// Timeout computation and limit checks for one request
`timescale 1ns / 1ps

module rbt_calc
  import rbt_pkg::*;
(
  input  cfg_t                   cfg,
  input  state_t                 state,
  input  logic                   req_type,
  input  logic signed [JitW-1:0] jitter_base,
  input  logic signed [JitW-1:0] jitter_cap,
  output result_t                result
);

  logic                    retry;
  logic [TimeW-1:0]        base;
  logic signed [WideW-1:0] base_val;
  logic signed [WideW-1:0] rt_base;
  logic signed [WideW-1:0] rt_cap;
  logic signed [WideW-1:0] rt;
  logic [TimeW-1:0]        nrt;
  logic [TimeW:0]          dur_sum;
  logic [TimeW-1:0]        total_sat;
  logic                    count_hit;
  logic                    dur_hit;

  assign retry = (req_type == REQ_RETRY);
  assign base  = retry ? state.cur_timeout : cfg.initial_timeout;

  always_comb begin
    // a retry doubles the previous timeout
    base_val = retry ? $signed({3'b000, state.cur_timeout, 1'b0})
                     : $signed({4'b0000, cfg.initial_timeout});
    rt_base  = base_val + jitter_term(jitter_base, base);
    rt_cap   = $signed({4'b0000, cfg.max_timeout}) + jitter_term(jitter_cap, cfg.max_timeout);
    if ((cfg.max_timeout != '0) && (rt_base > $signed({4'b0000, cfg.max_timeout}))) begin
      rt = rt_cap;
    end else begin
      rt = rt_base;
    end
    if (rt[WideW-1]) begin
      nrt = '0;
    end else if (rt[WideW-2:TimeW] != '0) begin
      nrt = TIME_MAX;
    end else begin
      nrt = rt[TimeW-1:0];
    end
  end

  assign dur_sum   = {1'b0, state.total_elapsed} + {1'b0, nrt};
  assign total_sat = dur_sum[TimeW] ? TIME_MAX : dur_sum[TimeW-1:0];
  assign count_hit = (cfg.max_count != '0) && (state.send_count >= cfg.max_count);
  assign dur_hit   = (cfg.max_duration != '0) && (dur_sum > {1'b0, cfg.max_duration});

  always_comb begin
    result.state         = state;
    result.scheduled     = 1'b1;
    result.give_up_cause = CAUSE_NONE;
    if (!retry) begin
      result.state.cur_timeout   = nrt;
      result.state.total_elapsed = nrt;
      result.state.send_count    = CountW'(1);
    end else if (count_hit) begin
      // give up, hold state
      result.scheduled     = 1'b0;
      result.give_up_cause = CAUSE_COUNT;
    end else if (dur_hit) begin
      result.scheduled     = 1'b0;
      result.give_up_cause = CAUSE_DURATION;
    end else begin
      result.state.cur_timeout   = nrt;
      result.state.total_elapsed = total_sat;
      if (state.send_count != COUNT_MAX) begin
        result.state.send_count = state.send_count + CountW'(1);
      end
    end
  end

endmodule

FILE: design/retransmit_backoff_timer.sv
// Top level: request register, back-off computation, state and result register
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------------
//   in       | in_valid / in_stall    | req_type, jitter_base, jitter_cap
//   out      | out_valid / out_stall  | scheduled, give_up_cause, timeout, attempts
//   cfg      | psel/penable/pready    | paddr, pwrite, pwdata, prdata
//
// One request per cycle unless the output stalls; results load from the request register.
// The timeout state is read and written in the single compute stage, so each
// request sees the outcome of the one before it without any wait.
// Reset (synchronous) clears the state to zero and loads the register defaults.
// An output stall holds the result register and a full request register behind it.
`timescale 1ns / 1ps

module retransmit_backoff_timer
  import rbt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   req_type,
  input  logic signed [JitW-1:0] jitter_base,
  input  logic signed [JitW-1:0] jitter_cap,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   scheduled,
  output logic [1:0]             give_up_cause,
  output logic [TimeW-1:0]       timeout,
  output logic [CountW-1:0]      attempts,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [AddrW-1:0]       paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  cfg_t                   cfg;
  state_t                 state;
  result_t                result;
  logic                   stage_valid;
  logic                   stage_type;
  logic signed [JitW-1:0] stage_jb;
  logic signed [JitW-1:0] stage_jc;
  logic                   advance;
  logic                   load_in;
  logic                   fire;

  rbt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rbt_calc u_calc (
    .cfg         (cfg),
    .state       (state),
    .req_type    (stage_type),
    .jitter_base (stage_jb),
    .jitter_cap  (stage_jc),
    .result      (result)
  );

  assign advance  = !out_valid || !out_stall;
  assign in_stall = stage_valid && !advance;
  assign load_in  = in_valid && !in_stall;
  assign fire     = stage_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (load_in) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      stage_type <= req_type;
      stage_jb   <= jitter_base;
      stage_jc   <= jitter_cap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else if (fire) begin
      state     <= result.state;
      out_valid <= 1'b1;
    end else if (advance) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      scheduled     <= result.scheduled;
      give_up_cause <= result.give_up_cause;
      timeout       <= result.state.cur_timeout;
      attempts      <= result.state.send_count;
    end
  end

endmodule

FILE: design/rbt_checker.sv
// Port-level checker for the back-off timer, bound to the top level
`timescale 1ns / 1ps
`include "retransmit_backoff_timer_macros.svh"

module rbt_checker
  import rbt_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              scheduled,
  input logic [1:0]        give_up_cause,
  input logic [TimeW-1:0]  timeout,
  input logic [CountW-1:0] attempts
);

  `RBT_ASSERT_NOW(a_cause_matches, clk, rst, out_valid, scheduled == (give_up_cause == CAUSE_NONE), "scheduled disagrees with give-up cause")
  `RBT_ASSERT_NOW(a_sched_counts, clk, rst, out_valid && scheduled, attempts != '0, "scheduled result with zero attempts")
  `RBT_ASSERT_NOW(a_stall_source, clk, rst, in_stall, out_valid && out_stall, "request stalled while output free")
  `RBT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(timeout) && $stable(attempts) && $stable(give_up_cause), "stalled result changed")

endmodule

bind retransmit_backoff_timer rbt_checker u_rbt_checker (.*);
